>>> src/pzrsb_pkg.sv
// ----------------------------------------------------------------------------
// pzrsb_pkg
// Shared widths, register offsets, the CORDIC arctangent table and the
// payload record carried through the ring divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

package pzrsb_pkg;

    // field and datapath widths
    localparam int COORD_BITS   = 20;
    localparam int ANGLE_BITS   = 16;
    localparam int NUM_ZONES    = 4;
    localparam int MAX_RINGS    = 15;
    localparam int CORDIC_ITERS = 24;
    localparam int RANGE_BITS   = 19;
    localparam int IDX_BITS     = 16;
    localparam int ZONE_BITS    = 2;
    localparam int RING_BITS    = 6;
    localparam int SECT_BITS    = 8;
    localparam int RCNT_BITS    = 4;
    localparam int CUT_BITS     = 16;
    localparam int ACC_BITS     = 32;
    localparam int CW           = 32;
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int REM_BITS     = COORD_BITS + 2;
    localparam int PROD_BITS    = RANGE_BITS + CUT_BITS;
    localparam int WIDTH_BITS   = COORD_BITS + 1;
    localparam int DIVN_BITS    = COORD_BITS + RCNT_BITS;
    localparam int SP_BITS      = ANGLE_BITS + SECT_BITS;
    localparam int DIV_STEPS    = RCNT_BITS;

    // latency from accepted start to result strobe
    localparam int POST_STAGES  = 5 + DIV_STEPS;
    localparam int LATENCY      = 2 + CORDIC_ITERS + POST_STAGES;

    // configuration port
    localparam int ADDR_BITS    = 6;
    localparam int DATA_BITS    = 64;
    localparam int REGIDX_BITS  = 3;

    localparam logic [REGIDX_BITS-1:0] REG_RANGE_MIN    = 3'd0;
    localparam logic [REGIDX_BITS-1:0] REG_RANGE_MAX    = 3'd1;
    localparam logic [REGIDX_BITS-1:0] REG_ZONE_CUTS    = 3'd2;
    localparam logic [REGIDX_BITS-1:0] REG_RING_COUNTS  = 3'd3;
    localparam logic [REGIDX_BITS-1:0] REG_SECT_COUNTS  = 3'd4;

    // record carried through the divider stages
    typedef struct packed {
        logic [IDX_BITS-1:0]   idx;
        logic [COORD_BITS-1:0] radius;
        logic                  inr;
        logic [ZONE_BITS-1:0]  zone;
        logic                  dpos;
        logic                  wpos;
        logic [RCNT_BITS-1:0]  rc;
        logic [RING_BITS-1:0]  base;
        logic [SECT_BITS-1:0]  sector;
        logic                  ovf;
        logic [COORD_BITS-1:0] div;
    } t_post;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [ACC_BITS-1:0] atan_turn(input int i);
        logic [ACC_BITS-1:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051D;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/polar_zone_ring_sector_binning_unit.sv
// ----------------------------------------------------------------------------
// polar_zone_ring_sector_binning_unit
// Polar binning of lidar points into concentric zones, rings and sectors.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a point on i_point_index, i_point_valid, i_x_mm and
//   i_y_mm; the point transfers at every clock edge where start is high, and
//   busy stays low, so one point per cycle is taken.
//   Each result appears on the o_* ports for one cycle with o_result_valid
//   high. Results keep input order. The pipeline is set by a 24-stage CORDIC
//   for the angle, with a 20-step square root running alongside it, then
//   nine stages of zone selection, ring division (four quotient steps) and
//   sector scaling.
//   The receiver cannot stall: every strobed result is taken.
//   Configuration goes through the APB port at byte address 8*i; write only
//   while no point is in flight. Derived zone limits are registered from
//   the written values through the span, product, start and end layers.
//   Synchronous reset clears the pipeline valid bits and loads the
//   register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_zone_ring_sector_binning_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire  [pzrsb_pkg::IDX_BITS-1:0]       i_point_index,
    input  wire                                  i_point_valid,
    input  wire  signed [pzrsb_pkg::COORD_BITS-1:0] i_x_mm,
    input  wire  signed [pzrsb_pkg::COORD_BITS-1:0] i_y_mm,
    output logic                                 o_result_valid,
    output logic [pzrsb_pkg::IDX_BITS-1:0]       o_index_out,
    output logic                                 o_in_range,
    output logic [pzrsb_pkg::ZONE_BITS-1:0]      o_zone_index,
    output logic [pzrsb_pkg::RING_BITS-1:0]      o_ring_index,
    output logic [pzrsb_pkg::SECT_BITS-1:0]      o_sector_index,
    output logic [pzrsb_pkg::COORD_BITS-1:0]     o_radius_mm,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [pzrsb_pkg::ADDR_BITS-1:0]      paddr,
    input  wire  [pzrsb_pkg::DATA_BITS-1:0]      pwdata,
    output logic [pzrsb_pkg::DATA_BITS-1:0]      prdata,
    output logic                                 pready
);
    import pzrsb_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [RANGE_BITS-1:0]          r_range_min;
    logic [RANGE_BITS-1:0]          r_range_max;
    logic [3*CUT_BITS-1:0]          r_zone_cuts;
    logic [NUM_ZONES*RCNT_BITS-1:0] r_ring_counts;
    logic [NUM_ZONES*SECT_BITS-1:0] r_sect_counts;
    logic                           cfg_wr;
    logic [REGIDX_BITS-1:0]         cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_BITS-1:3];

    // write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min   <= 19'd2700;
            r_range_max   <= 19'd80000;
            r_zone_cuts   <= 48'hC000_8000_4000;
            r_ring_counts <= 16'h4444;
            r_sect_counts <= 32'h2036_2010;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RANGE_MIN:   r_range_min   <= pwdata[RANGE_BITS-1:0];
                REG_RANGE_MAX:   r_range_max   <= pwdata[RANGE_BITS-1:0];
                REG_ZONE_CUTS:   r_zone_cuts   <= pwdata[3*CUT_BITS-1:0];
                REG_RING_COUNTS: r_ring_counts <= pwdata[NUM_ZONES*RCNT_BITS-1:0];
                REG_SECT_COUNTS: r_sect_counts <= pwdata[NUM_ZONES*SECT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (cfg_idx)
            REG_RANGE_MIN:   prdata = DATA_BITS'(r_range_min);
            REG_RANGE_MAX:   prdata = DATA_BITS'(r_range_max);
            REG_ZONE_CUTS:   prdata = DATA_BITS'(r_zone_cuts);
            REG_RING_COUNTS: prdata = DATA_BITS'(r_ring_counts);
            REG_SECT_COUNTS: prdata = DATA_BITS'(r_sect_counts);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // derived zone limits, four register layers behind the registers
    // ------------------------------------------------------------------
    logic [RANGE_BITS-1:0]  r_span;
    logic [PROD_BITS-1:0]   r_prod [1:NUM_ZONES-1];
    logic [RCNT_BITS-1:0]   r_rc   [0:NUM_ZONES-1];
    logic [RING_BITS-1:0]   r_base [0:NUM_ZONES-1];
    logic [SECT_BITS-1:0]   r_sc   [0:NUM_ZONES-1];
    logic [COORD_BITS-1:0]  r_st   [0:NUM_ZONES-1];
    logic [COORD_BITS-1:0]  r_en   [0:NUM_ZONES-1];
    logic signed [WIDTH_BITS-1:0] r_w [0:NUM_ZONES-1];
    logic [RCNT_BITS-1:0]   n_rc   [0:NUM_ZONES-1];
    logic [RING_BITS-1:0]   n_base [0:NUM_ZONES-1];
    logic [SECT_BITS-1:0]   n_sc   [0:NUM_ZONES-1];

    // clean up counts and accumulate ring bases
    always_comb begin
        for (int z = 0; z < NUM_ZONES; z++) begin
            n_rc[z] = r_ring_counts[z*RCNT_BITS +: RCNT_BITS];
            if (n_rc[z] == '0) begin
                n_rc[z] = RCNT_BITS'(1);
            end
            if (n_rc[z] > RCNT_BITS'(MAX_RINGS)) begin
                n_rc[z] = RCNT_BITS'(MAX_RINGS);
            end
            n_sc[z] = r_sect_counts[z*SECT_BITS +: SECT_BITS];
            if (n_sc[z] == '0) begin
                n_sc[z] = SECT_BITS'(1);
            end
        end
        n_base[0] = '0;
        for (int z = 1; z < NUM_ZONES; z++) begin
            n_base[z] = n_base[z-1] + RING_BITS'(n_rc[z-1]);
        end
    end

    // first layer: span and counts; second layer: span products
    always_ff @(posedge i_clk) begin
        r_span <= r_range_max - r_range_min;
        for (int z = 1; z < NUM_ZONES; z++) begin
            r_prod[z] <= PROD_BITS'(r_span) *
                         PROD_BITS'(r_zone_cuts[(z-1)*CUT_BITS +: CUT_BITS]);
        end
        for (int z = 0; z < NUM_ZONES; z++) begin
            r_rc[z]   <= n_rc[z];
            r_sc[z]   <= n_sc[z];
            r_base[z] <= n_base[z];
        end
    end

    // third layer: zone starts; fourth layer: zone ends and widths
    always_ff @(posedge i_clk) begin
        r_st[0] <= COORD_BITS'(r_range_min);
        for (int z = 1; z < NUM_ZONES; z++) begin
            r_st[z] <= COORD_BITS'(r_range_min) +
                       COORD_BITS'(r_prod[z][PROD_BITS-1:CUT_BITS]);
        end
        for (int z = 0; z < NUM_ZONES; z++) begin
            if (z + 1 < NUM_ZONES) begin
                r_en[z] <= r_st[z+1];
                r_w[z]  <= WIDTH_BITS'({1'b0, r_st[z+1]}) - WIDTH_BITS'({1'b0, r_st[z]});
            end else begin
                r_en[z] <= COORD_BITS'(r_range_max);
                r_w[z]  <= WIDTH_BITS'(r_range_max) - WIDTH_BITS'({1'b0, r_st[z]});
            end
        end
    end

    // ------------------------------------------------------------------
    // input capture and squares / pre-rotation
    // ------------------------------------------------------------------
    logic                           r_in_v;
    logic [IDX_BITS-1:0]            r_in_idx;
    logic                           r_in_pv;
    logic signed [COORD_BITS-1:0]   r_in_x;
    logic signed [COORD_BITS-1:0]   r_in_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_idx <= i_point_index;
        r_in_pv  <= i_point_valid;
        r_in_x   <= i_x_mm;
        r_in_y   <= i_y_mm;
    end

    logic                           r_v   [0:CORDIC_ITERS];
    logic [IDX_BITS-1:0]            r_idx [0:CORDIC_ITERS];
    logic                           r_pv  [0:CORDIC_ITERS];
    logic signed [CW-1:0]           r_cx  [0:CORDIC_ITERS];
    logic signed [CW-1:0]           r_cy  [0:CORDIC_ITERS];
    logic [ACC_BITS-1:0]            r_ca  [0:CORDIC_ITERS];
    logic [SQ_BITS-1:0]             r_rad [1:CORDIC_ITERS];
    logic [REM_BITS-1:0]            r_rem [1:CORDIC_ITERS];
    logic [COORD_BITS-1:0]          r_root[1:CORDIC_ITERS];
    logic [SQ_BITS-2:0]             r_xx;
    logic [SQ_BITS-2:0]             r_yy;

    logic signed [SQ_BITS-1:0]      xx_full;
    logic signed [SQ_BITS-1:0]      yy_full;
    logic signed [CW-1:0]           x_sc;
    logic signed [CW-1:0]           y_sc;

    assign xx_full = r_in_x * r_in_x;
    assign yy_full = r_in_y * r_in_y;
    assign x_sc    = {{(CW-COORD_BITS-8){r_in_x[COORD_BITS-1]}}, r_in_x, 8'h00};
    assign y_sc    = {{(CW-COORD_BITS-8){r_in_y[COORD_BITS-1]}}, r_in_y, 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_in_v;
        end
    end

    // fold the left half plane onto the right
    always_ff @(posedge i_clk) begin
        r_idx[0] <= r_in_idx;
        r_pv[0]  <= r_in_pv;
        r_xx     <= xx_full[SQ_BITS-2:0];
        r_yy     <= yy_full[SQ_BITS-2:0];
        if (r_in_x[COORD_BITS-1]) begin
            r_cx[0] <= -x_sc;
            r_cy[0] <= -y_sc;
            r_ca[0] <= {1'b1, {(ACC_BITS-1){1'b0}}};
        end else begin
            r_cx[0] <= x_sc;
            r_cy[0] <= y_sc;
            r_ca[0] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC iterations with the square root alongside
    // ------------------------------------------------------------------
    for (genvar j = 0; j < CORDIC_ITERS; j++) begin : g_stage
        logic signed [CW-1:0]  dx;
        logic signed [CW-1:0]  dy;
        logic signed [CW-1:0]  n_x;
        logic signed [CW-1:0]  n_y;
        logic [ACC_BITS-1:0]   n_a;
        logic [SQ_BITS-1:0]    n_rad;
        logic [REM_BITS-1:0]   n_rem;
        logic [COORD_BITS-1:0] n_root;

        // rotate towards the x axis
        always_comb begin
            dx = r_cy[j] >>> j;
            dy = r_cx[j] >>> j;
            if (!r_cy[j][CW-1]) begin
                n_x = r_cx[j] + dx;
                n_y = r_cy[j] - dy;
                n_a = r_ca[j] + atan_turn(j);
            end else begin
                n_x = r_cx[j] - dx;
                n_y = r_cy[j] + dy;
                n_a = r_ca[j] - atan_turn(j);
            end
        end

        if (j == 0) begin : g_sum
            // form the radicand
            always_comb begin
                n_rad  = {1'b0, r_xx} + {1'b0, r_yy};
                n_rem  = '0;
                n_root = '0;
            end
        end else if (j <= COORD_BITS) begin : g_sqrt
            logic [REM_BITS+1:0] rem_sh;
            logic [REM_BITS+1:0] trial;
            // one root bit per stage
            always_comb begin
                rem_sh = {r_rem[j], r_rad[j][SQ_BITS-1 -: 2]};
                trial  = {{(REM_BITS-COORD_BITS){1'b0}}, r_root[j], 2'b01};
                n_rad  = {r_rad[j][SQ_BITS-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_rem  = REM_BITS'(rem_sh - trial);
                    n_root = {r_root[j][COORD_BITS-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[REM_BITS-1:0];
                    n_root = {r_root[j][COORD_BITS-2:0], 1'b0};
                end
            end
        end else begin : g_hold
            always_comb begin
                n_rad  = r_rad[j];
                n_rem  = r_rem[j];
                n_root = r_root[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_idx[j+1]  <= r_idx[j];
            r_pv[j+1]   <= r_pv[j];
            r_cx[j+1]   <= n_x;
            r_cy[j+1]   <= n_y;
            r_ca[j+1]   <= n_a;
            r_rad[j+1]  <= n_rad;
            r_rem[j+1]  <= n_rem;
            r_root[j+1] <= n_root;
        end
    end

    // ------------------------------------------------------------------
    // range test and zone end compares
    // ------------------------------------------------------------------
    logic                   r_q1_v;
    logic [IDX_BITS-1:0]    r_q1_idx;
    logic [COORD_BITS-1:0]  r_q1_r;
    logic                   r_q1_inr;
    logic [NUM_ZONES-1:0]   r_q1_le;
    logic [ANGLE_BITS-1:0]  r_q1_theta;
    logic [COORD_BITS-1:0]  fin_r;

    assign fin_r = r_root[CORDIC_ITERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_v <= 1'b0;
        end else begin
            r_q1_v <= r_v[CORDIC_ITERS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1_idx   <= r_idx[CORDIC_ITERS];
        r_q1_r     <= r_pv[CORDIC_ITERS] ? fin_r : '0;
        r_q1_inr   <= r_pv[CORDIC_ITERS] && (fin_r > COORD_BITS'(r_range_min)) &&
                      (fin_r < COORD_BITS'(r_range_max));
        r_q1_theta <= r_ca[CORDIC_ITERS][ACC_BITS-1 -: ANGLE_BITS];
        for (int z = 0; z < NUM_ZONES; z++) begin
            r_q1_le[z] <= fin_r <= r_en[z];
        end
    end

    // ------------------------------------------------------------------
    // zone pick and per-zone values
    // ------------------------------------------------------------------
    logic                   r_q2_v;
    logic [IDX_BITS-1:0]    r_q2_idx;
    logic [COORD_BITS-1:0]  r_q2_r;
    logic                   r_q2_inr;
    logic [ZONE_BITS-1:0]   r_q2_z;
    logic [COORD_BITS-1:0]  r_q2_d;
    logic signed [WIDTH_BITS-1:0] r_q2_w;
    logic [RCNT_BITS-1:0]   r_q2_rc;
    logic [RING_BITS-1:0]   r_q2_base;
    logic [SECT_BITS-1:0]   r_q2_sc;
    logic [ANGLE_BITS-1:0]  r_q2_theta;
    logic [ZONE_BITS-1:0]   zsel;
    logic                   zfound;
    logic [COORD_BITS-1:0]  st_sel;

    // first zone whose end is not below the radius, else the last
    always_comb begin
        zsel   = ZONE_BITS'(NUM_ZONES - 1);
        zfound = 1'b0;
        for (int z = 0; z < NUM_ZONES; z++) begin
            if (!zfound && r_q1_le[z]) begin
                zsel   = ZONE_BITS'(z);
                zfound = 1'b1;
            end
        end
        st_sel = r_st[zsel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2_v <= 1'b0;
        end else begin
            r_q2_v <= r_q1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q2_idx   <= r_q1_idx;
        r_q2_r     <= r_q1_r;
        r_q2_inr   <= r_q1_inr;
        r_q2_z     <= zsel;
        r_q2_d     <= (r_q1_r > st_sel) ? (r_q1_r - st_sel) : '0;
        r_q2_w     <= r_w[zsel];
        r_q2_rc    <= r_rc[zsel];
        r_q2_base  <= r_base[zsel];
        r_q2_sc    <= r_sc[zsel];
        r_q2_theta <= r_q1_theta;
    end

    // ------------------------------------------------------------------
    // ring numerator and sector scaling
    // ------------------------------------------------------------------
    logic                   r_q3_v;
    t_post                  r_q3;
    logic [DIVN_BITS-1:0]   r_q3_n;
    logic [DIVN_BITS-1:0]   num_prod;
    logic [SP_BITS-1:0]     sect_prod;
    logic [SECT_BITS-1:0]   sect_raw;

    assign num_prod  = DIVN_BITS'(r_q2_d) * DIVN_BITS'(r_q2_rc);
    assign sect_prod = SP_BITS'(r_q2_theta) * SP_BITS'(r_q2_sc);
    assign sect_raw  = sect_prod[SP_BITS-1 -: SECT_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q3_v <= 1'b0;
        end else begin
            r_q3_v <= r_q2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q3_n        <= num_prod - DIVN_BITS'(1);
        r_q3.idx      <= r_q2_idx;
        r_q3.radius   <= r_q2_r;
        r_q3.inr      <= r_q2_inr;
        r_q3.zone     <= r_q2_z;
        r_q3.dpos     <= r_q2_d != '0;
        r_q3.wpos     <= !r_q2_w[WIDTH_BITS-1] && (r_q2_w != '0);
        r_q3.rc       <= r_q2_rc;
        r_q3.base     <= r_q2_base;
        r_q3.sector   <= (sect_raw > r_q2_sc - SECT_BITS'(1)) ?
                         (r_q2_sc - SECT_BITS'(1)) : sect_raw;
        r_q3.ovf      <= 1'b0;
        r_q3.div      <= r_q2_w[COORD_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // ring division: overflow test, then one quotient bit a stage
    // ------------------------------------------------------------------
    logic                   r_dv_v   [0:DIV_STEPS];
    t_post                  r_dv     [0:DIV_STEPS];
    logic [DIVN_BITS-1:0]   r_dv_rem [0:DIV_STEPS];
    logic [RCNT_BITS-1:0]   r_dv_q   [0:DIV_STEPS];
    t_post                  dv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_q3_v;
        end
    end

    // flag quotients that exceed the ring field
    always_comb begin
        dv_in     = r_q3;
        dv_in.ovf = r_q3_n >= (DIVN_BITS'(r_q3.div) << DIV_STEPS);
    end

    always_ff @(posedge i_clk) begin
        r_dv[0]     <= dv_in;
        r_dv_rem[0] <= r_q3_n;
        r_dv_q[0]   <= '0;
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int K = DIV_STEPS - 1 - s;
        logic [DIVN_BITS-1:0] cmp;

        assign cmp = DIVN_BITS'(r_dv[s].div) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s+1] <= 1'b0;
            end else begin
                r_dv_v[s+1] <= r_dv_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv[s+1] <= r_dv[s];
            if (r_dv_rem[s] >= cmp) begin
                r_dv_rem[s+1]  <= r_dv_rem[s] - cmp;
                r_dv_q[s+1]    <= r_dv_q[s] | RCNT_BITS'(1 << K);
            end else begin
                r_dv_rem[s+1]  <= r_dv_rem[s];
                r_dv_q[s+1]    <= r_dv_q[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // clamp ring, add zone base, drive result
    // ------------------------------------------------------------------
    t_post                  fin;
    logic [RCNT_BITS-1:0]   q_sat;
    logic [RCNT_BITS-1:0]   rc_top;
    logic [RCNT_BITS-1:0]   ring_loc;
    logic                   r_out_v;
    logic [IDX_BITS-1:0]    r_out_idx;
    logic                   r_out_inr;
    logic [ZONE_BITS-1:0]   r_out_zone;
    logic [RING_BITS-1:0]   r_out_ring;
    logic [SECT_BITS-1:0]   r_out_sect;
    logic [COORD_BITS-1:0]  r_out_radius;

    assign fin = r_dv[DIV_STEPS];

    always_comb begin
        q_sat  = fin.ovf ? {RCNT_BITS{1'b1}} : r_dv_q[DIV_STEPS];
        rc_top = fin.rc - RCNT_BITS'(1);
        if (!fin.dpos) begin
            ring_loc = '0;
        end else if (!fin.wpos || (q_sat > rc_top)) begin
            ring_loc = rc_top;
        end else begin
            ring_loc = q_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_idx    <= fin.idx;
        r_out_inr    <= fin.inr;
        r_out_radius <= fin.radius;
        if (fin.inr) begin
            r_out_zone <= fin.zone;
            r_out_ring <= fin.base + RING_BITS'(ring_loc);
            r_out_sect <= fin.sector;
        end else begin
            r_out_zone <= '0;
            r_out_ring <= '0;
            r_out_sect <= '0;
        end
    end

    assign o_result_valid = r_out_v;
    assign o_index_out    = r_out_idx;
    assign o_in_range     = r_out_inr;
    assign o_zone_index   = r_out_zone;
    assign o_ring_index   = r_out_ring;
    assign o_sector_index = r_out_sect;
    assign o_radius_mm    = r_out_radius;

endmodule

`default_nettype wire

>>> src/pzrsb_checker.sv
// ----------------------------------------------------------------------------
// pzrsb_checker
// Port-level checks on the binning unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pzrsb_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  start,
    input wire                                  busy,
    input wire                                  o_result_valid,
    input wire                                  o_in_range,
    input wire [pzrsb_pkg::ZONE_BITS-1:0]       o_zone_index,
    input wire [pzrsb_pkg::RING_BITS-1:0]       o_ring_index,
    input wire [pzrsb_pkg::SECT_BITS-1:0]       o_sector_index,
    input wire [pzrsb_pkg::COORD_BITS-1:0]      o_radius_mm
);
    import pzrsb_pkg::*;

    // every transfer yields its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_result_valid)
        else $error("result strobe missing after transfer");

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe after reset");

    // points out of range carry no bin
    a_no_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_in_range |->
        (o_zone_index == '0) && (o_ring_index == '0) && (o_sector_index == '0))
        else $error("bin fields set on an out of range point");

    // a binned point carries a non-zero radius
    a_binned_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_in_range |-> (o_radius_mm != '0))
        else $error("binned point with zero radius");

endmodule

bind polar_zone_ring_sector_binning_unit pzrsb_checker u_pzrsb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_in_range     (o_in_range),
    .o_zone_index   (o_zone_index),
    .o_ring_index   (o_ring_index),
    .o_sector_index (o_sector_index),
    .o_radius_mm    (o_radius_mm)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Polar zone/ring/sector binning testbench
// Drives lidar points through the command port, predicts each result with an
// independent fixed-point model (integer square root and CORDIC angle) and
// checks results in order. Registers are rewritten between idle phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import pzrsb_pkg::*;

    // one predicted or observed result
    typedef struct packed {
        logic [IDX_BITS-1:0]   idx;
        logic                  inr;
        logic [ZONE_BITS-1:0]  zone;
        logic [RING_BITS-1:0]  ring;
        logic [SECT_BITS-1:0]  sector;
        logic [COORD_BITS-1:0] radius;
    } t_bin;

    // ------------------------------------------------------------------------
    // Binning scoreboard: holds register copies and pending predicted bins
    // ------------------------------------------------------------------------
    class bin_scoreboard;
        logic [RANGE_BITS-1:0] rmin, rmax;
        logic [47:0]           cuts;
        logic [15:0]           rings;
        logic [31:0]           sects;
        t_bin                  pending[$];
        int                    mismatches;

        function void load_defaults();
            rmin = 19'd2700;
            rmax = 19'd80000;
            cuts = 48'hC000_8000_4000;
            rings = 16'h4444;
            sects = 32'h2036_2010;
            mismatches = 0;
        endfunction

        function void set_reg(int idx, logic [63:0] v);
            case (idx)
                REG_RANGE_MIN:   rmin = v[RANGE_BITS-1:0];
                REG_RANGE_MAX:   rmax = v[RANGE_BITS-1:0];
                REG_ZONE_CUTS:   cuts = v[47:0];
                REG_RING_COUNTS: rings = v[15:0];
                REG_SECT_COUNTS: sects = v[31:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // vectoring CORDIC, angle in 2^-32 turn
        function logic [31:0] turn_angle(longint xi, longint yi);
            longint cx, cy, dx, dy;
            logic [31:0] a;
            a = 0;
            cx = xi * 256;
            cy = yi * 256;
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                a = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx += dx; cy -= dy; a += atan_table(i);
                end else begin
                    cx -= dx; cy += dy; a -= atan_table(i);
                end
            end
            return a;
        endfunction

        function logic [31:0] atan_table(int i);
            logic [31:0] t[24] = '{
                32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
            return t[i];
        endfunction

        function longint zone_begin(int z, longint span);
            if (z == 0) return longint'(rmin);
            return longint'(rmin) + ((span * longint'(cuts[16*(z-1) +: 16])) >>> 16);
        endfunction

        function longint ring_cnt(int z);
            longint r;
            r = rings[4*z +: 4];
            if (r == 0) r = 1;
            if (r > MAX_RINGS) r = MAX_RINGS;
            return r;
        endfunction

        // predict the bin of one accepted point
        function void note_point(logic [15:0] idx, logic vld, logic signed [19:0] xv,
                                 logic signed [19:0] yv);
            t_bin b;
            longint xs, ys, r, span, st, en, d, w, base, rc, sc, th, sec, rg;
            int z;
            b = '0;
            b.idx = idx;
            xs = xv;
            ys = yv;
            if (vld) begin
                r = root_floor(xs * xs + ys * ys);
                b.radius = r[COORD_BITS-1:0];
                if (r > rmin && r < rmax) begin
                    span = longint'(rmax) - longint'(rmin);
                    base = 0;
                    for (z = 0; z < NUM_ZONES; z++) begin
                        st = zone_begin(z, span);
                        en = (z + 1 < NUM_ZONES) ? zone_begin(z + 1, span) : longint'(rmax);
                        if (r <= en || z + 1 == NUM_ZONES) break;
                        base += ring_cnt(z);
                    end
                    rc = ring_cnt(z);
                    d = r > st ? r - st : 0;
                    w = en - st;
                    rg = 0;
                    if (d > 0 && w > 0) begin
                        rg = (d * rc - 1) / w;
                        if (rg > rc - 1) rg = rc - 1;
                    end else if (d > 0) begin
                        rg = rc - 1;
                    end
                    sc = sects[8*z +: 8];
                    if (sc == 0) sc = 1;
                    th = turn_angle(xs, ys) >> (32 - ANGLE_BITS);
                    sec = (th * sc) >> ANGLE_BITS;
                    if (sec > sc - 1) sec = sc - 1;
                    b.inr = 1'b1;
                    b.zone = z[1:0];
                    b.ring = 6'(rg + base);
                    b.sector = sec[7:0];
                end
            end
            pending.insert(pending.size(), b);
        endfunction

        function void check_bin(t_bin got);
            t_bin e;
            if (pending.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) report("mismatch", e, got);
        endfunction

        function void report(string what, t_bin e, t_bin g);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: exp idx=%0d inr=%0d z=%0d ring=%0d sec=%0d r=%0d",
                         what, e.idx, e.inr, e.zone, e.ring, e.sector, e.radius,
                         " | got idx=%0d inr=%0d z=%0d ring=%0d sec=%0d r=%0d",
                         g.idx, g.inr, g.zone, g.ring, g.sector, g.radius);
        endfunction
    endclass

    logic                         i_clk, i_rst_n, start;
    logic                         busy;
    logic [IDX_BITS-1:0]          i_point_index;
    logic                         i_point_valid;
    logic signed [COORD_BITS-1:0] i_x_mm, i_y_mm;
    logic                         o_result_valid, o_in_range;
    logic [IDX_BITS-1:0]          o_index_out;
    logic [ZONE_BITS-1:0]         o_zone_index;
    logic [RING_BITS-1:0]         o_ring_index;
    logic [SECT_BITS-1:0]         o_sector_index;
    logic [COORD_BITS-1:0]        o_radius_mm;
    logic                         psel, penable, pwrite, pready;
    logic [ADDR_BITS-1:0]         paddr;
    logic [DATA_BITS-1:0]         pwdata, prdata;

    bin_scoreboard sb;
    int            point_no;

    polar_zone_ring_sector_binning_unit dut (.*);

    // 20 ns clock
    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // check each strobed result at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_bin('{o_index_out, o_in_range, o_zone_index, o_ring_index,
                           o_sector_index, o_radius_mm});
    end

    // write one register over APB, only while idle
    task automatic write_reg(int idx, logic [63:0] v);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = ADDR_BITS'(8 * idx); pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // hand one point over and note the transfer
    task automatic send_point(logic vld, logic signed [19:0] xv, logic signed [19:0] yv,
                              int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_point_index = 16'(point_no);
        i_point_valid = vld;
        i_x_mm = xv;
        i_y_mm = yv;
        do @(posedge i_clk); while (busy);
        sb.note_point(i_point_index, vld, xv, yv);
        point_no = point_no + $urandom_range(1, 3000);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // mostly radii inside the limits, at random angles
    task automatic random_point(int gap);
        logic signed [19:0] xv, yv;
        int                 sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            int rr;
            rr = $urandom_range(0, 120000);
            xv = 20'($signed($urandom_range(0, 2 * rr)) - rr);
            yv = 20'($signed($urandom_range(0, 2 * rr)) - rr);
        end else begin
            xv = 20'($urandom);
            yv = 20'($urandom);
        end
        send_point($urandom_range(0, 9) != 0, xv, yv, gap);
    endtask

    // run n random points, in blocks of 60 that alternate back-to-back and random gaps
    task automatic random_phase(int n);
        int gap;
        for (int i = 0; i < n; i++) begin
            if ((i / 60) % 2 == 0) gap = 0;
            else gap = $urandom_range(0, 18);
            random_point(gap);
        end
    endtask

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [63:0] set_vals[5];
        sb = new();
        sb.load_defaults();
        point_no = 0;
        start = 1'b0; i_rst_n = 1'b0;
        i_point_index = '0; i_point_valid = 1'b0; i_x_mm = '0; i_y_mm = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, axes, invalid, limits
        send_point(1'b1, 20'sd5000, 20'sd0, 0);
        send_point(1'b1, -20'sd5000, 20'sd0, 0);
        send_point(1'b1, 20'sd0, 20'sd5000, 0);
        send_point(1'b1, 20'sd0, -20'sd5000, 1);
        send_point(1'b0, 20'sd3000, 20'sd3000, 0);
        send_point(1'b0, -20'sd1, -20'sd1, 0);
        send_point(1'b1, 20'sd2700, 20'sd0, 0);
        send_point(1'b1, 20'sd2701, 20'sd0, 0);
        send_point(1'b1, 20'sd80000, 20'sd0, 0);
        send_point(1'b1, 20'sd79999, 20'sd0, 2);
        send_point(1'b1, -20'sd524288, -20'sd524288, 0);
        send_point(1'b1, 20'sd524287, 20'sd524287, 0);
        send_point(1'b1, -20'sd524288, 20'sd524287, 0);
        send_point(1'b1, 20'sd0, 20'sd0, 0);
        send_point(1'b1, 20'sd30000, -20'sd1, 0);
        send_point(1'b1, -20'sd30000, 20'sd1, 3);
        send_point(1'b1, 20'sd21975, 20'sd0, 0);
        send_point(1'b1, 20'sd21976, 20'sd0, 0);
        send_point(1'b1, 20'sd41000, -20'sd41000, 0);
        random_phase(300);

        // pause until every expected result is in
        drain();
        random_phase(200);
        drain();

        // extreme settings: empty span, all zero counts, full counts
        write_reg(REG_RANGE_MIN, 64'h7FFFF);
        write_reg(REG_RANGE_MAX, 64'h0);
        random_phase(60);
        drain();
        write_reg(REG_RANGE_MIN, 64'h0);
        write_reg(REG_RANGE_MAX, 64'h7FFFF);
        write_reg(REG_ZONE_CUTS, 64'h0);
        write_reg(REG_RING_COUNTS, 64'h0);
        write_reg(REG_SECT_COUNTS, 64'h0);
        random_phase(150);
        drain();
        write_reg(REG_ZONE_CUTS, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_RING_COUNTS, 64'hFFFF);
        write_reg(REG_SECT_COUNTS, 64'hFFFF_FFFF);
        random_phase(150);
        drain();
        // unsorted cuts
        write_reg(REG_RANGE_MIN, 64'd100);
        write_reg(REG_RANGE_MAX, 64'd150000);
        write_reg(REG_ZONE_CUTS, 64'h2000_F000_8000);
        write_reg(REG_RING_COUNTS, 64'h0F1A);
        write_reg(REG_SECT_COUNTS, 64'h01FF_0080);
        random_phase(150);

        // random settings
        for (int k = 0; k < 4; k++) begin
            drain();
            set_vals[0] = $urandom_range(0, 20000);
            set_vals[1] = set_vals[0] + $urandom_range(1, 200000);
            set_vals[2] = {$urandom, $urandom};
            set_vals[3] = $urandom;
            set_vals[4] = $urandom;
            for (int r = 0; r < 5; r++) write_reg(r, set_vals[r]);
            random_phase(150);
        end

        drain();
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/pzrsb_pkg.sv
src/polar_zone_ring_sector_binning_unit.sv
src/pzrsb_checker.sv
tb/testbench.sv
